### sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared widths, request and status codes and sequencer states for the
// bounded double-ended queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_COUNT      = 3'd4,
    ACT_SEARCH     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_POP_DATA,
    ST_SRCH,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

### sv/bdq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, written when the write enable is set and read
// otherwise; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue with search
// Ring-buffered deque of 32-bit words with push and pop at either end, a
// count query and a front-to-back search for the first equal entry.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (in_valid_i, in_stall_o) with an
// action code and a value. Each request gives exactly one item on the output
// channel (out_valid_o, out_stall_i): a status, the 1-based position of a
// search hit, the entry count after the request and any popped word.
// Requests are handled one at a time; in_stall_o is high while a request is
// in progress. A count request or an unused code goes straight to the
// response, and a search reads the held entries, at most DEPTH, until the
// first hit. The search reads one entry per cycle from the single-port
// entry memory and compares it with the value. The result waits in an
// output register; a stalled receiver holds it there and the block can
// still accept the next request, which then waits for the register before
// its own result is delivered. Reset empties the queue and clears the
// output valid flag; the memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [2:0]                         action_i,
  input  wire logic signed [bdq_pkg::DATA_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [1:0]                         status_o,
  output logic      [$clog2(DEPTH+1)-1:0]         position_o,
  output logic      [$clog2(DEPTH+1)-1:0]         item_count_o,
  output logic signed [bdq_pkg::DATA_W-1:0]       popped_value_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

  bdq_pkg::state_e state_q, state_d;

  bdq_pkg::action_e           act_q, act_d;
  logic [bdq_pkg::DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]              front_q, front_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              chk_idx_q, chk_idx_d;
  logic                       chk_valid_q, chk_valid_d;

  bdq_pkg::status_e           res_status_q, res_status_d;
  logic [CW-1:0]              res_pos_q, res_pos_d;
  logic [bdq_pkg::DATA_W-1:0] res_pop_q, res_pop_d;

  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_status_q, out_status_d;
  logic [CW-1:0]              out_pos_q, out_pos_d;
  logic [CW-1:0]              out_count_q, out_count_d;
  logic [bdq_pkg::DATA_W-1:0] out_pop_q, out_pop_d;

  logic                       accept;
  logic                       out_free;
  logic                       full;
  logic                       empty;
  logic                       hit;
  logic [CW-1:0]              offset;
  logic [CW:0]                ring_sum;
  logic [AW-1:0]              ring_addr;
  logic [AW-1:0]              front_dec;
  logic [AW-1:0]              front_inc;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [bdq_pkg::DATA_W-1:0] ram_rdata;

  assign accept    = in_valid_i && (state_q == bdq_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = (count_q == DEPTH_C);
  assign empty     = (count_q == '0);
  assign hit       = chk_valid_q && (ram_rdata == val_q);
  assign front_dec = (front_q == '0) ? LAST_C : front_q - AW'(1);
  assign front_inc = (front_q == LAST_C) ? '0 : front_q + AW'(1);

  // Shared ring address unit: front plus an offset, wrapped once.
  assign ring_sum  = {{(CW + 1 - AW){1'b0}}, front_q} + {1'b0, offset};
  assign ring_addr = (ring_sum >= DEPTH_S) ? AW'(ring_sum - DEPTH_S) : ring_sum[AW-1:0];

  bdq_ram #(
    .WIDTH(bdq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(val_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (bdq_pkg::action_e'(action_i))
            bdq_pkg::ACT_PUSH_FRONT,
            bdq_pkg::ACT_PUSH_BACK:  state_d = bdq_pkg::ST_PUSH;
            bdq_pkg::ACT_POP_FRONT,
            bdq_pkg::ACT_POP_BACK:   state_d = bdq_pkg::ST_POP;
            bdq_pkg::ACT_SEARCH:     state_d = bdq_pkg::ST_SRCH;
            default:                 state_d = bdq_pkg::ST_RESP;
          endcase
        end
      end
      bdq_pkg::ST_PUSH:     state_d = bdq_pkg::ST_RESP;
      bdq_pkg::ST_POP:      state_d = empty ? bdq_pkg::ST_RESP : bdq_pkg::ST_POP_DATA;
      bdq_pkg::ST_POP_DATA: state_d = bdq_pkg::ST_RESP;
      bdq_pkg::ST_SRCH: begin
        if (hit || (idx_q >= count_q)) begin
          state_d = bdq_pkg::ST_RESP;
        end
      end
      bdq_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = bdq_pkg::ST_IDLE;
        end
      end
      default: state_d = bdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act_d        = act_q;
    val_d        = val_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    chk_idx_d    = chk_idx_q;
    chk_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_pop_d    = res_pop_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_pop_d    = out_pop_q;
    offset       = '0;
    ram_we       = 1'b0;
    ram_addr     = ring_addr;

    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          act_d        = bdq_pkg::action_e'(action_i);
          val_d        = value_i;
          idx_d        = '0;
          res_status_d = bdq_pkg::STS_OK;
          res_pos_d    = '0;
          res_pop_d    = '0;
        end
      end
      bdq_pkg::ST_PUSH: begin
        offset = count_q;
        if (full) begin
          res_status_d = bdq_pkg::STS_FULL;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
          if (act_q == bdq_pkg::ACT_PUSH_FRONT) begin
            ram_addr = front_dec;
            front_d  = front_dec;
          end
        end
      end
      bdq_pkg::ST_POP: begin
        offset = count_q - CW'(1);
        if (empty) begin
          res_status_d = bdq_pkg::STS_EMPTY;
        end else if (act_q == bdq_pkg::ACT_POP_FRONT) begin
          ram_addr = front_q;
        end
      end
      bdq_pkg::ST_POP_DATA: begin
        res_pop_d = ram_rdata;
        count_d   = count_q - CW'(1);
        if (act_q == bdq_pkg::ACT_POP_FRONT) begin
          front_d = front_inc;
        end
      end
      bdq_pkg::ST_SRCH: begin
        offset = idx_q;
        if (hit) begin
          res_status_d = bdq_pkg::STS_OK;
          res_pos_d    = chk_idx_q + CW'(1);
        end else if (idx_q < count_q) begin
          chk_valid_d = 1'b1;
          chk_idx_d   = idx_q;
          idx_d       = idx_q + CW'(1);
        end else begin
          res_status_d = bdq_pkg::STS_NOT_FOUND;
        end
      end
      bdq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          out_count_d  = count_q;
          out_pop_d    = res_pop_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_pop_q    <= res_pop_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
    out_pop_q    <= out_pop_d;
  end

  assign in_stall_o     = (state_q != bdq_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign position_o     = out_pos_q;
  assign item_count_o   = out_count_q;
  assign popped_value_o = out_pop_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count exceeds the depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_C)
    else $error("front index outside the ring");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != bdq_pkg::ST_IDLE))
    else $error("accepted item did not start a request");

  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdq_pkg::ST_SRCH) |-> (idx_q <= count_q))
    else $error("search index ran past the held entries");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |->
      ($past(state_q) == bdq_pkg::ST_RESP))
    else $error("result item delivered outside the response state");
`endif

endmodule

`default_nettype wire
